@@ src/cfa_pkg.sv @@
// ----------------------------------------------------------------------------
// cfa_pkg
// Shared types and codes of the contiguous frame allocator: result status
// codes, sequencer states and the control/status bundles of the address walker.
// ----------------------------------------------------------------------------
package cfa_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned COUNT_W = 11;

  // Result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NOMEM    = 2'd1;
  localparam logic [1:0] STAT_NOTFOUND = 2'd2;
  localparam logic [1:0] STAT_ZERO     = 2'd3;

  // Request codes
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Register indexes
  localparam logic REG_FRAME_BASE  = 1'b0;
  localparam logic REG_FRAME_COUNT = 1'b1;

  // Bit positions in a frame map entry
  localparam int unsigned USED_BIT  = 1;
  localparam int unsigned CHAIN_BIT = 0;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_ASCAN  = 6'b000100,
    ST_AMARK  = 6'b001000,
    ST_FSRCH  = 6'b010000,
    ST_FCHAIN = 6'b100000
  } state_e;

  typedef struct packed {
    logic load;  // restart at frame zero
    logic step;  // advance by one frame
  } walk_ctrl_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              match;
  } walk_stat_t;

endpackage

@@ src/cfa_ram.sv @@
// ----------------------------------------------------------------------------
// cfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cfa_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ src/cfa_walker.sv @@
// ----------------------------------------------------------------------------
// cfa_walker
// Shared address unit: holds the physical address of the current frame,
// steps it by one page and compares it with the address being freed.
// ----------------------------------------------------------------------------
module cfa_walker #(
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic                       clk_i,
  input  cfa_pkg::walk_ctrl_t        ctrl_i,
  input  logic [cfa_pkg::ADDR_W-1:0] base_i,
  input  logic [cfa_pkg::ADDR_W-1:0] target_i,
  output cfa_pkg::walk_stat_t        stat_o
);

  localparam logic [cfa_pkg::ADDR_W-1:0] Step = cfa_pkg::ADDR_W'(PAGE_BYTES);

  logic [cfa_pkg::ADDR_W-1:0] addr_q, addr_d;

  always_comb begin
    addr_d = addr_q;
    if (ctrl_i.load) begin
      addr_d = base_i;
    end else if (ctrl_i.step) begin
      addr_d = addr_q + Step;  // wraps modulo 2^32
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
  end

  assign stat_o.addr  = addr_q;
  assign stat_o.match = (addr_q == target_i);

endmodule

@@ src/contiguous_frame_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// contiguous_frame_allocator_unit
// First-fit allocator of contiguous physical page frames.
// ----------------------------------------------------------------------------
// Pulse start with action/page_count/address while busy is low. An allocate
// scans the frame map one frame a cycle for the lowest free run of page_count
// frames, then marks the run one frame a cycle. A free walks the frame
// addresses one frame a cycle to find the matching frame, then clears it and
// follows the chain one frame a cycle. The frame map is a RAM with one write
// port and one registered read port; one frame per cycle through it sets the
// rate.
// A zero-size, oversize or empty-range request is answered without a scan; a
// free chain may run on past the active frame count up to the last frame of
// the store. A new item is taken in the cycle the previous result is shown.
// The result is shown on status_o and base_address_o for one cycle with
// done_o high; there is no back-pressure. After reset the map is swept to
// zero with busy high.
// The register port (cfg_*) is always ready; write it only while idle.
// ----------------------------------------------------------------------------
module contiguous_frame_allocator_unit #(
  parameter int unsigned MAX_FRAMES = 1024,
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        action_i,
  input  logic [cfa_pkg::COUNT_W-1:0] page_count_i,
  input  logic [cfa_pkg::ADDR_W-1:0]  address_i,
  output logic                        done_o,
  output logic [1:0]                  status_o,
  output logic [cfa_pkg::ADDR_W-1:0]  base_address_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_index_i,
  input  logic [cfa_pkg::ADDR_W-1:0]  cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(MAX_FRAMES);
  localparam int unsigned CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int unsigned CMP_W = (CNT_W > cfa_pkg::COUNT_W) ? CNT_W : cfa_pkg::COUNT_W;
  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(MAX_FRAMES - 1);
  localparam logic [CMP_W-1:0] MaxExt  = CMP_W'(MAX_FRAMES);

  cfa_pkg::state_e state_q, state_d;

  logic [cfa_pkg::ADDR_W-1:0]  frame_base_q;
  logic [cfa_pkg::COUNT_W-1:0] frame_count_q;

  logic [IDX_W-1:0]           idx_q, idx_d;
  logic [CNT_W-1:0]           run_q, run_d;
  logic [CNT_W-1:0]           want_q, want_d;
  logic [CNT_W-1:0]           rem_q, rem_d;
  logic [IDX_W-1:0]           run_idx_q, run_idx_d;
  logic [cfa_pkg::ADDR_W-1:0] run_addr_q, run_addr_d;
  logic [cfa_pkg::ADDR_W-1:0] target_q, target_d;

  logic                       done_q, done_d;
  logic [1:0]                 status_q, status_d;
  logic [cfa_pkg::ADDR_W-1:0] base_q, base_d;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [1:0]       ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [1:0]       ram_rdata;

  cfa_pkg::walk_ctrl_t wk_ctrl;
  cfa_pkg::walk_stat_t wk_stat;

  logic [CMP_W-1:0] count_ext;
  logic [CMP_W-1:0] want_ext;
  logic [CNT_W-1:0] lim;
  logic [CNT_W-1:0] idx_inc;
  logic [CNT_W-1:0] run_inc;
  logic             scan_last;
  logic             accept;

  // Active frame count is the register clipped to the store depth
  assign count_ext = CMP_W'(frame_count_q);
  assign want_ext  = CMP_W'(page_count_i);
  assign lim       = (count_ext > MaxExt) ? CNT_W'(MaxExt) : CNT_W'(count_ext);
  assign idx_inc   = CNT_W'(idx_q) + CNT_W'(1);
  assign run_inc   = run_q + CNT_W'(1);
  assign scan_last = (idx_inc == lim);
  assign accept    = start && !busy;

  cfa_ram #(
    .WIDTH (2),
    .DEPTH (MAX_FRAMES)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  cfa_walker #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_walker (
    .clk_i    (clk_i),
    .ctrl_i   (wk_ctrl),
    .base_i   (frame_base_q),
    .target_i (target_q),
    .stat_o   (wk_stat)
  );

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    run_d      = run_q;
    want_d     = want_q;
    rem_d      = rem_q;
    run_idx_d  = run_idx_q;
    run_addr_d = run_addr_q;
    target_d   = target_q;
    done_d     = 1'b0;
    status_d   = status_q;
    base_d     = base_q;
    ram_we     = 1'b0;
    ram_waddr  = idx_q;
    ram_wdata  = 2'b00;
    ram_raddr  = '0;
    wk_ctrl    = '0;

    case (state_q)
      cfa_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        if (idx_q == LastIdx) begin
          idx_d   = '0;
          state_d = cfa_pkg::ST_IDLE;
        end else begin
          idx_d = IDX_W'(idx_inc);
        end
      end

      cfa_pkg::ST_IDLE: begin
        // Frame zero is read here so its entry is ready on the first scan cycle
        ram_raddr = '0;
        if (accept) begin
          idx_d        = '0;
          run_d        = '0;
          target_d     = address_i;
          wk_ctrl.load = 1'b1;
          base_d       = '0;
          if (action_i == cfa_pkg::ACT_ALLOC) begin
            if (want_ext == '0) begin
              done_d   = 1'b1;
              status_d = cfa_pkg::STAT_ZERO;
            end else if (want_ext > CMP_W'(lim)) begin
              done_d   = 1'b1;
              status_d = cfa_pkg::STAT_NOMEM;
            end else begin
              want_d  = CNT_W'(want_ext);
              state_d = cfa_pkg::ST_ASCAN;
            end
          end else begin
            if (lim == '0) begin
              done_d   = 1'b1;
              status_d = cfa_pkg::STAT_NOTFOUND;
            end else begin
              state_d = cfa_pkg::ST_FSRCH;
            end
          end
        end
      end

      cfa_pkg::ST_ASCAN: begin
        // Read one frame ahead; ram_rdata belongs to idx_q
        ram_raddr = IDX_W'(idx_inc);
        if (ram_rdata[cfa_pkg::USED_BIT]) begin
          run_d = '0;
          if (scan_last) begin
            done_d   = 1'b1;
            status_d = cfa_pkg::STAT_NOMEM;
            state_d  = cfa_pkg::ST_IDLE;
          end else begin
            idx_d        = IDX_W'(idx_inc);
            wk_ctrl.step = 1'b1;
          end
        end else if (run_inc == want_q) begin
          idx_d      = (run_q == '0) ? idx_q : run_idx_q;
          run_addr_d = (run_q == '0) ? wk_stat.addr : run_addr_q;
          rem_d      = want_q;
          state_d    = cfa_pkg::ST_AMARK;
        end else begin
          run_d = run_inc;
          if (run_q == '0) begin
            run_idx_d  = idx_q;
            run_addr_d = wk_stat.addr;
          end
          if (scan_last) begin
            done_d   = 1'b1;
            status_d = cfa_pkg::STAT_NOMEM;
            state_d  = cfa_pkg::ST_IDLE;
          end else begin
            idx_d        = IDX_W'(idx_inc);
            wk_ctrl.step = 1'b1;
          end
        end
      end

      cfa_pkg::ST_AMARK: begin
        ram_we                       = 1'b1;
        ram_wdata[cfa_pkg::USED_BIT] = 1'b1;
        ram_wdata[cfa_pkg::CHAIN_BIT] = (rem_q != CNT_W'(1));
        if (rem_q == CNT_W'(1)) begin
          done_d   = 1'b1;
          status_d = cfa_pkg::STAT_OK;
          base_d   = run_addr_q;
          state_d  = cfa_pkg::ST_IDLE;
        end else begin
          idx_d = IDX_W'(idx_inc);
          rem_d = rem_q - CNT_W'(1);
        end
      end

      cfa_pkg::ST_FSRCH: begin
        // Read the candidate so its entry is ready if it matches
        ram_raddr = idx_q;
        if (wk_stat.match) begin
          state_d = cfa_pkg::ST_FCHAIN;
        end else if (scan_last) begin
          done_d   = 1'b1;
          status_d = cfa_pkg::STAT_NOTFOUND;
          state_d  = cfa_pkg::ST_IDLE;
        end else begin
          idx_d        = IDX_W'(idx_inc);
          wk_ctrl.step = 1'b1;
        end
      end

      cfa_pkg::ST_FCHAIN: begin
        ram_raddr = IDX_W'(idx_inc);
        ram_we    = 1'b1;
        if (ram_rdata[cfa_pkg::CHAIN_BIT] && (idx_q != LastIdx)) begin
          idx_d = IDX_W'(idx_inc);
        end else begin
          done_d   = 1'b1;
          status_d = cfa_pkg::STAT_OK;
          state_d  = cfa_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = cfa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= cfa_pkg::ST_CLEAR;
      idx_q         <= '0;
      done_q        <= 1'b0;
      frame_base_q  <= '0;
      frame_count_q <= cfa_pkg::COUNT_W'(1024);
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          cfa_pkg::REG_FRAME_BASE:  frame_base_q  <= cfg_data_i;
          cfa_pkg::REG_FRAME_COUNT: frame_count_q <= cfg_data_i[cfa_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    run_q      <= run_d;
    want_q     <= want_d;
    rem_q      <= rem_d;
    run_idx_q  <= run_idx_d;
    run_addr_q <= run_addr_d;
    target_q   <= target_d;
    status_q   <= status_d;
    base_q     <= base_d;
  end

  assign busy           = (state_q != cfa_pkg::ST_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign base_address_o = base_q;

  // Only the clearing sweep, run marking and chain release write the map
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == cfa_pkg::ST_CLEAR || state_q == cfa_pkg::ST_AMARK ||
                state_q == cfa_pkg::ST_FCHAIN))
    else $error("frame map written outside a writing state");

  // A scan never holds a run already as long as the request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cfa_pkg::ST_ASCAN) |-> (run_q < want_q))
    else $error("scan run count reached the request size");

  // Marking always has frames left to mark
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cfa_pkg::ST_AMARK) |-> (rem_q != '0))
    else $error("marking with no frames remaining");

  // Only a successful result carries a nonzero address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != cfa_pkg::STAT_OK) |-> (base_address_o == '0))
    else $error("failed result with nonzero address");

  // A finished item leaves the block idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while still busy");

endmodule

@@ tb/sv/contiguous_frame_allocator_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_frame_allocator_unit_test
// Self-checking bench for the first-fit frame allocator. A mirror of the used
// and chain maps predicts every reply from the accepted requests. A short
// directed sequence covers the refusals, address wrap, partial frees and
// chains that run past a lowered frame count. Random phases follow, each with
// its own base and frame count, issuing bursts of mostly well-formed
// allocate/free traffic with random gaps.
// ----------------------------------------------------------------------------
module contiguous_frame_allocator_unit_test;

  localparam int unsigned ADDR_W      = cfa_pkg::ADDR_W;
  localparam int unsigned COUNT_W     = cfa_pkg::COUNT_W;
  localparam int unsigned MAX_FRAMES  = 1024;
  localparam int unsigned PAGE_BYTES  = 4096;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 34;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] addr;
  } reply_t;

  typedef struct {
    int unsigned first_idx;
    int unsigned len;
  } run_t;

  class frame_alloc_mirror;
    bit                 used_q  [MAX_FRAMES];
    bit                 chain_q [MAX_FRAMES];
    logic [ADDR_W-1:0]  frame_base;
    logic [COUNT_W-1:0] frame_count;
    reply_t             pending [$];
    int unsigned        errors;

    function new();
      frame_base  = '0;
      frame_count = 11'd1024;
      errors      = 0;
    endfunction

    function void write_reg(logic idx, logic [ADDR_W-1:0] data);
      if (idx == cfa_pkg::REG_FRAME_BASE) begin
        frame_base = data;
      end else begin
        frame_count = data[COUNT_W-1:0];
      end
    endfunction

    function int unsigned active();
      if (32'(frame_count) > MAX_FRAMES) begin
        return MAX_FRAMES;
      end
      return 32'(frame_count);
    endfunction

    function logic [ADDR_W-1:0] addr_of(int unsigned idx);
      return frame_base + idx * PAGE_BYTES;
    endfunction

    function reply_t predict(logic act, logic [COUNT_W-1:0] want, logic [ADDR_W-1:0] addr);
      reply_t            r;
      int unsigned       lim;
      int unsigned       need;
      int unsigned       run;
      int unsigned       base_idx;
      int unsigned       idx;
      logic [ADDR_W-1:0] diff;
      bit                found;
      bit                more;
      lim      = active();
      need     = 32'(want);
      r.status = cfa_pkg::STAT_NOMEM;
      r.addr   = '0;
      run      = 0;
      base_idx = 0;
      found    = 1'b0;
      if (act == cfa_pkg::ACT_ALLOC) begin
        if (need == 0) begin
          r.status = cfa_pkg::STAT_ZERO;
        end else if (need <= lim) begin
          for (idx = 0; idx < lim && !found; idx++) begin
            if (used_q[idx]) begin
              run = 0;
            end else begin
              run++;
              if (run == need) begin
                found    = 1'b1;
                base_idx = idx + 1 - need;
              end
            end
          end
          if (found) begin
            // chain every frame of the run but the last
            for (idx = base_idx; idx < base_idx + need; idx++) begin
              used_q[idx]  = 1'b1;
              chain_q[idx] = (idx != base_idx + need - 1);
            end
            r.status = cfa_pkg::STAT_OK;
            r.addr   = addr_of(base_idx);
          end
        end
      end else begin
        diff = addr - frame_base;
        if ((diff % PAGE_BYTES) != 0 || (diff / PAGE_BYTES) >= lim) begin
          r.status = cfa_pkg::STAT_NOTFOUND;
        end else begin
          idx  = diff / PAGE_BYTES;
          more = 1'b1;
          // follow the chain through the whole store, even past the count
          while (more) begin
            more         = chain_q[idx] && (idx + 1 < MAX_FRAMES);
            used_q[idx]  = 1'b0;
            chain_q[idx] = 1'b0;
            idx++;
          end
          r.status = cfa_pkg::STAT_OK;
        end
      end
      return r;
    endfunction

    function reply_t note_request(logic act, logic [COUNT_W-1:0] want,
                                  logic [ADDR_W-1:0] addr);
      reply_t r;
      r = predict(act, want, addr);
      pending.push_back(r);
      return r;
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_reply(logic [1:0] st, logic [ADDR_W-1:0] ba);
      reply_t want_r;
      if (pending.size() == 0) begin
        report($sformatf("reply with nothing pending: status %0d base %h", st, ba));
        return;
      end
      want_r = pending.pop_front();
      if (st !== want_r.status) begin
        report($sformatf("status %0d, predicted %0d", st, want_r.status));
      end
      if (ba !== want_r.addr) begin
        report($sformatf("base_address %h, predicted %h", ba, want_r.addr));
      end
    endtask
  endclass

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                start        = 1'b0;
  logic                busy;
  logic                action_i     = cfa_pkg::ACT_ALLOC;
  logic [COUNT_W-1:0]  page_count_i = '0;
  logic [ADDR_W-1:0]   address_i    = '0;
  logic                done_o;
  logic [1:0]          status_o;
  logic [ADDR_W-1:0]   base_address_o;
  logic                cfg_valid_i  = 1'b0;
  logic                cfg_ready_o;
  logic                cfg_index_i  = cfa_pkg::REG_FRAME_BASE;
  logic [ADDR_W-1:0]   cfg_data_i   = '0;

  frame_alloc_mirror mirror = new();
  run_t              live_runs [$];
  int unsigned       burst_left;
  int unsigned       stall_cycles = 0;

  contiguous_frame_allocator_unit #(
    .MAX_FRAMES(MAX_FRAMES),
    .PAGE_BYTES(PAGE_BYTES)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .action_i      (action_i),
    .page_count_i  (page_count_i),
    .address_i     (address_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .base_address_o(base_address_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      mirror.check_reply(status_o, base_address_o);
    end
  end

  // count cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t watchdog: no transfer for %0d cycles", $time, stall_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic drain();
    while (mirror.pending.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] count);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= cfa_pkg::REG_FRAME_BASE;
    cfg_data_i  <= base;
    do @(posedge clk_i); while (!cfg_ready_o);
    mirror.write_reg(cfa_pkg::REG_FRAME_BASE, base);
    cfg_index_i <= cfa_pkg::REG_FRAME_COUNT;
    cfg_data_i  <= count;
    do @(posedge clk_i); while (!cfg_ready_o);
    mirror.write_reg(cfa_pkg::REG_FRAME_COUNT, count);
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= $urandom();
    @(posedge clk_i);
  endtask

  // Leaves start high; a burst ends with pause().
  task automatic send_item(logic act, logic [COUNT_W-1:0] cnt, logic [ADDR_W-1:0] addr);
    reply_t r;
    run_t   run;
    if (!start) start <= 1'b1;
    action_i     <= act;
    page_count_i <= cnt;
    address_i    <= addr;
    do @(posedge clk_i); while (busy);
    r = mirror.note_request(act, cnt, addr);
    if (act == cfa_pkg::ACT_ALLOC && r.status == cfa_pkg::STAT_OK) begin
      run.first_idx = (r.addr - mirror.frame_base) / PAGE_BYTES;
      run.len       = 32'(cnt);
      live_runs.push_back(run);
    end
  endtask

  task automatic pause();
    start <= 1'b0;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(20, 60)) @(posedge clk_i);
    end else begin
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic next_item(logic act, logic [COUNT_W-1:0] cnt, logic [ADDR_W-1:0] addr);
    send_item(act, cnt, addr);
    burst_left--;
    if (burst_left == 0) begin
      pause();
      burst_left = $urandom_range(1, 16);
    end
  endtask

  task automatic end_phase();
    if (start) start <= 1'b0;
    drain();
  endtask

  task automatic random_item();
    logic               act;
    logic [COUNT_W-1:0] cnt;
    logic [ADDR_W-1:0]  addr;
    int unsigned        lim;
    int unsigned        pick;
    int unsigned        k;
    int unsigned        off;
    run_t               run;
    lim  = mirror.active();
    pick = $urandom_range(0, 99);
    cnt  = COUNT_W'($urandom_range(0, 2047));
    addr = $urandom();
    if (pick < 50) begin
      act = cfa_pkg::ACT_ALLOC;
      case ($urandom_range(0, 19))
        0:       cnt = '0;
        1:       cnt = COUNT_W'($urandom_range(0, 2047));
        2:       cnt = COUNT_W'(lim);
        3:       cnt = COUNT_W'(lim + 1);
        4:       cnt = COUNT_W'($urandom_range(1, 64));
        default: cnt = COUNT_W'($urandom_range(1, 8));
      endcase
    end else if (pick < 88 && live_runs.size() != 0) begin
      // release a known run, now and then from its middle
      act = cfa_pkg::ACT_FREE;
      k   = $urandom_range(0, live_runs.size() - 1);
      run = live_runs[k];
      live_runs.delete(k);
      off = 0;
      if (run.len > 1 && $urandom_range(0, 5) == 0) begin
        off = $urandom_range(1, run.len - 1);
      end
      addr = mirror.addr_of(run.first_idx + off);
    end else begin
      act = cfa_pkg::ACT_FREE;
      case ($urandom_range(0, 3))
        0:       addr = $urandom();
        1:       addr = mirror.addr_of($urandom_range(0, MAX_FRAMES - 1));
        2:       addr = mirror.addr_of($urandom_range(0, lim)) + $urandom_range(1, PAGE_BYTES - 1);
        default: addr = mirror.addr_of(lim + $urandom_range(0, 3));
      endcase
    end
    next_item(act, cnt, addr);
  endtask

  initial begin
    burst_left = $urandom_range(1, 16);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    // hold off until the map sweep is done
    @(posedge clk_i);
    drain();

    // count register with every bit set clamps to the store depth;
    // base sits four pages below the wrap
    set_config(32'hFFFF_C000, 32'hFFFF_FFFF);
    next_item(cfa_pkg::ACT_ALLOC, 11'd0, $urandom());
    next_item(cfa_pkg::ACT_ALLOC, 11'd1, $urandom());
    next_item(cfa_pkg::ACT_ALLOC, 11'd3, $urandom());
    next_item(cfa_pkg::ACT_ALLOC, 11'd5, $urandom());
    next_item(cfa_pkg::ACT_ALLOC, 11'd2047, $urandom());
    next_item(cfa_pkg::ACT_ALLOC, 11'd1025, $urandom());
    next_item(cfa_pkg::ACT_ALLOC, 11'd1024, $urandom());
    next_item(cfa_pkg::ACT_FREE, COUNT_W'($urandom_range(0, 2047)), mirror.addr_of(1) + 4);
    next_item(cfa_pkg::ACT_FREE, COUNT_W'($urandom_range(0, 2047)),
              mirror.addr_of(MAX_FRAMES));
    next_item(cfa_pkg::ACT_FREE, 11'd2047, 32'hFFFF_FFFF);
    next_item(cfa_pkg::ACT_FREE, 11'd0, mirror.addr_of(2));
    next_item(cfa_pkg::ACT_ALLOC, 11'd2, $urandom());
    next_item(cfa_pkg::ACT_FREE, COUNT_W'($urandom_range(0, 2047)), mirror.addr_of(600));
    next_item(cfa_pkg::ACT_FREE, COUNT_W'($urandom_range(0, 2047)), mirror.addr_of(0));
    next_item(cfa_pkg::ACT_ALLOC, 11'd1, $urandom());
    next_item(cfa_pkg::ACT_FREE, COUNT_W'($urandom_range(0, 2047)), 32'h0000_0000);
    next_item(cfa_pkg::ACT_ALLOC, 11'd1020, $urandom());
    next_item(cfa_pkg::ACT_FREE, COUNT_W'($urandom_range(0, 2047)), mirror.addr_of(4));
    end_phase();

    // lower the count under a live run, then free into it
    set_config(32'h0000_0000, 32'd1024);
    next_item(cfa_pkg::ACT_ALLOC, 11'd6, $urandom());
    end_phase();
    set_config(32'h0000_0000, 32'd6);
    next_item(cfa_pkg::ACT_FREE, COUNT_W'($urandom_range(0, 2047)), mirror.addr_of(5));
    next_item(cfa_pkg::ACT_ALLOC, 11'd1, $urandom());
    end_phase();
    set_config(32'h0000_0000, 32'd0);
    next_item(cfa_pkg::ACT_ALLOC, 11'd1, $urandom());
    next_item(cfa_pkg::ACT_FREE, COUNT_W'($urandom_range(0, 2047)), mirror.addr_of(0));
    end_phase();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_config(32'h0000_0000, 32'd1024);
        1: set_config(32'hFFFF_F000, $urandom_range(4, 40));
        2: set_config($urandom(), 32'd1);
        3: set_config($urandom() & 32'hFFFF_F000,
                      ($urandom() & 32'hFFFF_F800) | $urandom_range(1025, 2047));
        4: set_config($urandom(), 32'd0);
        5: set_config($urandom() & 32'hFFFF_F000, 32'd2);
        6: set_config($urandom(), $urandom_range(3, 64));
        default: set_config(32'hFFFF_FFFF, $urandom_range(100, 1024));
      endcase
      repeat (PHASE_ITEMS) random_item();
      end_phase();
    end

    // any late reply shows up as unexpected
    repeat (2 * MAX_FRAMES + 16) @(posedge clk_i);
    if (mirror.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
